// ----- src/assert_macros.svh -----
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/pmpb_pkg.sv -----
// Shared types and codes for the Prim spanning tree builder.
// Used by the controller, the datapath and the checker.
package pmpb_pkg;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;

    typedef enum logic [3:0] {
        DP_CLR,
        DP_IDLE,
        DP_ADD_A,
        DP_ADD_B,
        DP_INIT,
        DP_SCAN,
        DP_RELAX,
        DP_EMIT_RD,
        DP_EMIT_WR
    } t_dp_op;

    typedef struct packed {
        logic       clr_last;
        logic       sweep_done;
        logic       found;
        logic       idx_end;
        logic       out_free;
        logic       add_ok;
        logic [1:0] in_action;
    } t_dp_status;

endpackage

// ----- src/pmpb_ctrl.sv -----
// Controller state machine of the spanning tree builder.
// Depends on pmpb_pkg for the datapath command and status types.
module pmpb_ctrl import pmpb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_dp_op     o_op,
    output logic       o_in_stall
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_A,
        S_ADD_B,
        S_INIT,
        S_SCAN,
        S_RELAX,
        S_EMIT_RD,
        S_EMIT_WR
    } t_state;

    t_state r_state, n_state;
    t_dp_op r_op, n_op;
    logic   r_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_status.in_action)
                        ACT_CLEAR: n_state = S_CLEAR;
                        ACT_ADD:   n_state = i_status.add_ok ? S_ADD_A : S_IDLE;
                        ACT_RUN:   n_state = S_INIT;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_A: n_state = S_ADD_B;
            S_ADD_B: n_state = S_IDLE;
            S_INIT:  n_state = S_SCAN;
            S_SCAN: begin
                if (i_status.sweep_done) n_state = i_status.found ? S_RELAX : S_EMIT_RD;
            end
            S_RELAX: begin
                if (i_status.sweep_done) n_state = S_SCAN;
            end
            S_EMIT_RD: n_state = i_status.idx_end ? S_IDLE : S_EMIT_WR;
            S_EMIT_WR: begin
                if (i_status.out_free) n_state = S_EMIT_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        unique case (n_state)
            S_CLEAR:   n_op = DP_CLR;
            S_IDLE:    n_op = DP_IDLE;
            S_ADD_A:   n_op = DP_ADD_A;
            S_ADD_B:   n_op = DP_ADD_B;
            S_INIT:    n_op = DP_INIT;
            S_SCAN:    n_op = DP_SCAN;
            S_RELAX:   n_op = DP_RELAX;
            S_EMIT_RD: n_op = DP_EMIT_RD;
            S_EMIT_WR: n_op = DP_EMIT_WR;
            default:   n_op = DP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_op    <= DP_CLR;
            r_stall <= 1'b1;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_op       = r_op;
    assign o_in_stall = r_stall;

endmodule

// ----- src/pmpb_dpath.sv -----
// Datapath of the spanning tree builder: cost and key memories, counters,
// minimum search, relaxation and the output register.
// Depends on pmpb_pkg for the command and status types.
module pmpb_dpath import pmpb_pkg::*; #(
    parameter int MAX_VERTICES = 32,
    parameter int COST_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_op             i_op,
    output t_dp_status         o_status,
    input  logic               i_in_valid,
    input  logic [1:0]         i_action,
    input  logic [4:0]         i_src_vertex,
    input  logic [4:0]         i_dst_vertex,
    input  logic signed [15:0] i_edge_cost,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [5:0]         i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [4:0]         o_child_vertex,
    output logic [4:0]         o_parent_vertex,
    output logic signed [15:0] o_tree_edge_cost,
    output logic               o_reachable,
    output logic               o_last
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = COST_BITS + 16;
    localparam int KPW   = COST_BITS + VW;

    logic [COST_BITS:0] r_cost_mem [DEPTH];
    logic [KPW-1:0]     r_kp_mem [MAX_VERTICES];
    logic [COST_BITS:0] r_cost_q;
    logic [KPW-1:0]     r_kp_q;

    logic [CW-1:0]           r_vcount, n_vcount;
    logic [CW-1:0]           r_idx;
    logic [AW-1:0]           r_clr_addr;
    logic                    r_pipe_vld;
    logic [VW-1:0]           r_pipe_idx;
    logic [VW-1:0]           r_u;
    logic signed [COST_BITS-1:0] r_best;
    logic                    r_found;
    logic [MAX_VERTICES-1:0] r_in_tree;
    logic [MAX_VERTICES-1:0] r_key_ok;
    logic [4:0]              r_src, r_dst;
    logic [COST_BITS-1:0]    r_cost;

    logic               r_out_valid;
    logic [4:0]         r_out_child, r_out_parent;
    logic signed [15:0] r_out_cost;
    logic               r_out_ok, r_out_last;

    logic [VW-1:0]               idx_v;
    logic                        idx_end, sweep_done, out_free, clr_last;
    logic signed [COST_BITS-1:0] q_key, q_cost;
    logic [VW-1:0]               q_par;
    logic                        q_present;
    logic                        scan_hit, relax_hit;
    logic signed [EW-1:0]        in_cost_ext, key_ext;
    logic                        emit_ok;

    logic               cost_we, cost_re;
    logic [AW-1:0]      cost_wa, cost_ra;
    logic [COST_BITS:0] cost_wd;
    logic               kp_we, kp_re;
    logic [VW-1:0]      kp_wa;
    logic [KPW-1:0]     kp_wd;

    assign idx_v      = r_idx[VW-1:0];
    assign idx_end    = (r_idx == r_vcount);
    assign sweep_done = idx_end && !r_pipe_vld;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign clr_last   = (r_clr_addr == AW'(DEPTH - 1));

    assign q_key     = $signed(r_kp_q[COST_BITS-1:0]);
    assign q_par     = r_kp_q[KPW-1:COST_BITS];
    assign q_cost    = $signed(r_cost_q[COST_BITS-1:0]);
    assign q_present = r_cost_q[COST_BITS];

    assign in_cost_ext = EW'(i_edge_cost);
    assign key_ext     = EW'(q_key);
    assign emit_ok     = r_in_tree[idx_v];

    assign scan_hit = (i_op == DP_SCAN) && r_pipe_vld && !r_in_tree[r_pipe_idx]
                      && r_key_ok[r_pipe_idx] && (!r_found || (q_key < r_best));

    assign relax_hit = (i_op == DP_RELAX) && r_pipe_vld && !r_in_tree[r_pipe_idx]
                       && q_present && (!r_key_ok[r_pipe_idx] || (q_cost < q_key));

    always_comb begin
        if (i_cfg_data == 6'd0) begin
            n_vcount = CW'(1);
        end else if (32'(i_cfg_data) > MAX_VERTICES) begin
            n_vcount = CW'(MAX_VERTICES);
        end else begin
            n_vcount = CW'(i_cfg_data);
        end
    end

    always_comb begin
        cost_we = 1'b0;
        cost_wa = '0;
        cost_wd = '0;
        kp_we   = 1'b0;
        kp_wa   = '0;
        kp_wd   = '0;
        unique case (i_op)
            DP_CLR: begin
                cost_we = 1'b1;
                cost_wa = r_clr_addr;
            end
            DP_ADD_A: begin
                cost_we = 1'b1;
                cost_wa = AW'(r_src) * AW'(MAX_VERTICES) + AW'(r_dst);
                cost_wd = {1'b1, r_cost};
            end
            DP_ADD_B: begin
                cost_we = 1'b1;
                cost_wa = AW'(r_dst) * AW'(MAX_VERTICES) + AW'(r_src);
                cost_wd = {1'b1, r_cost};
            end
            DP_INIT: begin
                kp_we = 1'b1;
            end
            DP_RELAX: begin
                kp_we = relax_hit;
                kp_wa = r_pipe_idx;
                kp_wd = {r_u, q_cost};
            end
            default: begin
            end
        endcase
    end

    assign cost_re = (i_op == DP_RELAX) && !idx_end;
    assign cost_ra = AW'(r_u) * AW'(MAX_VERTICES) + AW'(idx_v);
    assign kp_re   = ((i_op == DP_SCAN) || (i_op == DP_RELAX) || (i_op == DP_EMIT_RD))
                     && !idx_end;

    always_ff @(posedge i_clk) begin
        if (cost_we) r_cost_mem[cost_wa] <= cost_wd;
        if (cost_re) r_cost_q <= r_cost_mem[cost_ra];
    end

    always_ff @(posedge i_clk) begin
        if (kp_we) r_kp_mem[kp_wa] <= kp_wd;
        if (kp_re) r_kp_q <= r_kp_mem[idx_v];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= CW'(1);
            r_idx       <= '0;
            r_clr_addr  <= '0;
            r_pipe_vld  <= 1'b0;
            r_found     <= 1'b0;
            r_in_tree   <= '0;
            r_key_ok    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_vcount <= n_vcount;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            unique case (i_op)
                DP_CLR: begin
                    r_clr_addr <= clr_last ? '0 : r_clr_addr + AW'(1);
                end
                DP_INIT: begin
                    r_idx      <= '0;
                    r_found    <= 1'b0;
                    r_in_tree  <= '0;
                    r_key_ok   <= MAX_VERTICES'(1);
                    r_pipe_vld <= 1'b0;
                end
                DP_SCAN: begin
                    r_pipe_vld <= !idx_end;
                    if (!idx_end) r_idx <= r_idx + CW'(1);
                    if (scan_hit) r_found <= 1'b1;
                    if (sweep_done) begin
                        if (r_found) begin
                            r_in_tree[r_u] <= 1'b1;
                            r_idx          <= '0;
                        end else begin
                            r_idx <= CW'(1);
                        end
                    end
                end
                DP_RELAX: begin
                    r_pipe_vld <= !idx_end;
                    if (!idx_end) r_idx <= r_idx + CW'(1);
                    if (relax_hit) r_key_ok[r_pipe_idx] <= 1'b1;
                    if (sweep_done) begin
                        r_idx   <= '0;
                        r_found <= 1'b0;
                    end
                end
                DP_EMIT_WR: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_idx       <= r_idx + CW'(1);
                    end
                end
                default: begin
                    r_pipe_vld <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe_idx <= idx_v;
        if ((i_op == DP_IDLE) && i_in_valid) begin
            r_src  <= i_src_vertex;
            r_dst  <= i_dst_vertex;
            r_cost <= in_cost_ext[COST_BITS-1:0];
        end
        if (scan_hit) begin
            r_u    <= r_pipe_idx;
            r_best <= q_key;
        end
        if ((i_op == DP_EMIT_WR) && out_free) begin
            r_out_child  <= 5'(r_idx);
            r_out_parent <= emit_ok ? 5'(q_par) : 5'd0;
            r_out_cost   <= emit_ok ? key_ext[15:0] : 16'sd0;
            r_out_ok     <= emit_ok;
            r_out_last   <= (r_idx == r_vcount - CW'(1));
        end
    end

    always_comb begin
        o_status.clr_last   = clr_last;
        o_status.sweep_done = sweep_done;
        o_status.found      = r_found;
        o_status.idx_end    = idx_end;
        o_status.out_free   = out_free;
        o_status.add_ok     = (32'(i_src_vertex) < MAX_VERTICES)
                              && (32'(i_dst_vertex) < MAX_VERTICES);
        o_status.in_action  = i_action;
    end

    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_child_vertex   = r_out_child;
    assign o_parent_vertex  = r_out_parent;
    assign o_tree_edge_cost = r_out_cost;
    assign o_reachable      = r_out_ok;
    assign o_last           = r_out_last;

endmodule

// ----- src/prim_mst_parent_builder_core.sv -----
// Prim minimum spanning tree builder over a stored cost matrix. After reset
// and after every clear item the block sweeps the cost memory, one entry a
// cycle, all MAX_VERTICES*MAX_VERTICES entries (1024 at the defaults), and stalls
// its input meanwhile; configuration writes are taken at any time. An add item
// writes the cost once per direction, in states ADD_A and ADD_B. A run item for n
// vertices does up to n rounds of a key scan and a relaxation pass, then reports
// each vertex but vertex 0 through states EMIT_RD and EMIT_WR; each pass visits
// every vertex once through the single read port of the key memory. Results wait
// in an output register, so the next item is taken while the last result is still held.
// Depends on pmpb_pkg, pmpb_ctrl and pmpb_dpath.
module prim_mst_parent_builder_core import pmpb_pkg::*; #(
    parameter int MAX_VERTICES = 32,
    parameter int COST_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [4:0]         i_src_vertex,
    input  logic [4:0]         i_dst_vertex,
    input  logic signed [15:0] i_edge_cost,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [5:0]         i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [4:0]         o_child_vertex,
    output logic [4:0]         o_parent_vertex,
    output logic signed [15:0] o_tree_edge_cost,
    output logic               o_reachable,
    output logic               o_last
);

    t_dp_op     op;
    t_dp_status status;

    pmpb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_op       (op),
        .o_in_stall (o_in_stall)
    );

    pmpb_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COST_BITS    (COST_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .o_status         (status),
        .i_in_valid       (i_in_valid),
        .i_action         (i_action),
        .i_src_vertex     (i_src_vertex),
        .i_dst_vertex     (i_dst_vertex),
        .i_edge_cost      (i_edge_cost),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_child_vertex   (o_child_vertex),
        .o_parent_vertex  (o_parent_vertex),
        .o_tree_edge_cost (o_tree_edge_cost),
        .o_reachable      (o_reachable),
        .o_last           (o_last)
    );

endmodule

// ----- src/pmpb_checker.sv -----
// Port-level assertions for the spanning tree builder, bound to the top level.
// Depends on pmpb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pmpb_checker import pmpb_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [1:0]         i_action,
    input logic [4:0]         i_src_vertex,
    input logic [4:0]         i_dst_vertex,
    input logic signed [15:0] i_edge_cost,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [5:0]         i_cfg_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [4:0]         o_child_vertex,
    input logic [4:0]         o_parent_vertex,
    input logic signed [15:0] o_tree_edge_cost,
    input logic               o_reachable,
    input logic               o_last
);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_child_vertex) && $stable(o_parent_vertex) && $stable(o_tree_edge_cost) && $stable(o_reachable) && $stable(o_last)), "stalled result transfer changed")
    `ASSERT_CLK_ALWAYS(a_reset_sweep, i_clk, (!i_rst_n) |=> o_in_stall, "input not stalled for the clearing sweep")
    `ASSERT_CLK(a_clear_sweep, i_clk, i_rst_n, (i_in_valid && !o_in_stall && (i_action == ACT_CLEAR)) |=> o_in_stall, "clear transfer not followed by a sweep")
    `ASSERT_CLK(a_unreach_zero, i_clk, i_rst_n, (o_out_valid && !o_reachable) |-> ((o_parent_vertex == 5'd0) && (o_tree_edge_cost == 16'sd0)), "unreachable vertex with parent or cost")

endmodule

bind prim_mst_parent_builder_core pmpb_checker u_checker (.*);

// ----- verif/prim_mst_parent_builder_core_tb.sv -----
// Self-checking testbench for prim_mst_parent_builder_core: a directed table, then random
// clear/add/run sequences; a spanning tree predictor or the table checks every reported link.
// Depends on pmpb_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module prim_mst_parent_builder_core_tb;
    import pmpb_pkg::*;

    localparam logic [1:0] ACT_NOP = 2'd3;
    localparam int VERTS = 32;
    localparam int KEY_INF = 32768;
    localparam int RAND_ITEMS = 410;
    localparam int SETTLE_CYCLES = 1200;
    localparam int HOLD_CYCLES = 400;
    localparam int END_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int IDLE_PCT [4] = '{0, 50, 0, 36};
    localparam int STALL_PCT [4] = '{0, 0, 50, 36};

    typedef struct packed {
        logic [4:0]         child;
        logic [4:0]         parent;
        logic signed [15:0] cost;
        logic               reachable;
        logic               last;
    } t_tree_link;

    typedef struct packed {
        logic               set_count;
        logic [5:0]         count_val;
        logic [1:0]         action;
        logic [4:0]         src;
        logic [4:0]         dst;
        logic signed [15:0] cost;
        logic               typed;
        t_tree_link         want;
    } t_plan_row;

    localparam t_tree_link NO_LINK = '0;
    localparam t_tree_link LONE_UNREACHED = '{5'd1, 5'd0, 16'sh0000, 1'b0, 1'b1};
    localparam t_tree_link LONE_MIN = '{5'd1, 5'd0, 16'sh8000, 1'b1, 1'b1};
    localparam t_tree_link LONE_MAX = '{5'd1, 5'd0, 16'sh7FFF, 1'b1, 1'b1};

    localparam t_plan_row PLAN [27] = '{
        '{1'b0, 6'd0,  ACT_RUN,   5'd0,  5'd0,  16'sh0000, 1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_NOP,   5'd31, 5'd31, 16'shFFFF, 1'b0, NO_LINK},
        '{1'b1, 6'd0,  ACT_CLEAR, 5'd0,  5'd0,  16'sh0000, 1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_RUN,   5'd0,  5'd0,  16'sh0000, 1'b0, NO_LINK},
        '{1'b1, 6'd2,  ACT_CLEAR, 5'd0,  5'd0,  16'sh0000, 1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_RUN,   5'd0,  5'd0,  16'sh0000, 1'b1, LONE_UNREACHED},
        '{1'b0, 6'd0,  ACT_ADD,   5'd0,  5'd1,  16'sh8000, 1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_RUN,   5'd0,  5'd0,  16'sh0000, 1'b1, LONE_MIN},
        '{1'b0, 6'd0,  ACT_ADD,   5'd1,  5'd0,  16'sh7FFF, 1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_RUN,   5'd0,  5'd0,  16'sh0000, 1'b1, LONE_MAX},
        '{1'b0, 6'd0,  ACT_ADD,   5'd1,  5'd1,  16'shFFFB, 1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_RUN,   5'd0,  5'd0,  16'sh0000, 1'b1, LONE_MAX},
        '{1'b0, 6'd0,  ACT_CLEAR, 5'd31, 5'd31, 16'shFFFF, 1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_RUN,   5'd0,  5'd0,  16'sh0000, 1'b1, LONE_UNREACHED},
        '{1'b1, 6'd63, ACT_CLEAR, 5'd0,  5'd0,  16'sh0000, 1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_ADD,   5'd31, 5'd30, 16'sd100,  1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_ADD,   5'd0,  5'd31, 16'shFFFF, 1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_ADD,   5'd0,  5'd30, 16'sd200,  1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_RUN,   5'd0,  5'd0,  16'sh0000, 1'b0, NO_LINK},
        '{1'b1, 6'd33, ACT_CLEAR, 5'd0,  5'd0,  16'sh0000, 1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_RUN,   5'd0,  5'd0,  16'sh0000, 1'b0, NO_LINK},
        '{1'b1, 6'd4,  ACT_CLEAR, 5'd0,  5'd0,  16'sh0000, 1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_ADD,   5'd0,  5'd5,  16'shFFF7, 1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_ADD,   5'd0,  5'd2,  16'sd7,    1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_ADD,   5'd2,  5'd3,  16'sd7,    1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_ADD,   5'd0,  5'd1,  16'sd7,    1'b0, NO_LINK},
        '{1'b0, 6'd0,  ACT_RUN,   5'd0,  5'd0,  16'sh0000, 1'b0, NO_LINK}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_action;
    logic [4:0]         i_src_vertex;
    logic [4:0]         i_dst_vertex;
    logic signed [15:0] i_edge_cost;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [5:0]         i_cfg_data;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [4:0]         o_child_vertex;
    logic [4:0]         o_parent_vertex;
    logic signed [15:0] o_tree_edge_cost;
    logic               o_reachable;
    logic               o_last;

    logic signed [15:0] link_cost [VERTS][VERTS];
    bit                 link_on [VERTS][VERTS];
    int                 n_verts = 1;
    t_tree_link         tree_q [$];

    int          in_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_ask = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          runs_sent = 0;
    int          links_checked = 0;
    int          count_writes = 0;
    int unsigned cycle_count = 0;

    prim_mst_parent_builder_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_src_vertex     (i_src_vertex),
        .i_dst_vertex     (i_dst_vertex),
        .i_edge_cost      (i_edge_cost),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_child_vertex   (o_child_vertex),
        .o_parent_vertex  (o_parent_vertex),
        .o_tree_edge_cost (o_tree_edge_cost),
        .o_reachable      (o_reachable),
        .o_last           (o_last)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d links outstanding",
                     cycle_count, tree_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(negedge i_clk) begin : monitor
        t_tree_link w;
        if (i_rst_n === 1'b1 && o_out_valid && !i_out_stall) begin
            links_checked++;
            if (tree_q.size() == 0) begin
                $display("%0t ns: unexpected transfer, expected none, got child %0d", $time,
                         o_child_vertex);
                mismatches++;
            end else begin
                w = tree_q.pop_front();
                check_field("child_vertex", w.child, o_child_vertex);
                check_field("parent_vertex", w.parent, o_parent_vertex);
                check_field("tree_edge_cost", w.cost, o_tree_edge_cost);
                check_field("reachable", w.reachable, o_reachable);
                check_field("last", w.last, o_last);
            end
        end
    end

    task automatic grow_tree();
        int key [VERTS];
        int par [VERTS];
        bit joined [VERTS];
        int u;
        int best;
        t_tree_link r;
        for (int i = 0; i < VERTS; i++) begin
            key[i] = KEY_INF;
            par[i] = 0;
            joined[i] = 1'b0;
        end
        key[0] = 0;
        for (int round = 0; round < n_verts; round++) begin
            u = n_verts;
            best = KEY_INF;
            for (int i = 0; i < n_verts; i++) begin
                if (!joined[i] && key[i] < KEY_INF && (u == n_verts || key[i] < best)) begin
                    u = i;
                    best = key[i];
                end
            end
            if (u == n_verts) break;
            joined[u] = 1'b1;
            for (int v = 0; v < n_verts; v++) begin
                if (!joined[v] && link_on[u][v] && int'(link_cost[u][v]) < key[v]) begin
                    key[v] = link_cost[u][v];
                    par[v] = u;
                end
            end
        end
        for (int v = 1; v < n_verts; v++) begin
            r.child = 5'(v);
            r.parent = joined[v] ? 5'(par[v]) : 5'd0;
            r.cost = joined[v] ? 16'(key[v]) : 16'sd0;
            r.reachable = joined[v];
            r.last = (v == n_verts - 1);
            tree_q.push_back(r);
        end
    endtask

    task automatic send_item(input logic [1:0] act, input logic [4:0] src,
                             input logic [4:0] dst, input logic signed [15:0] cost,
                             input bit typed, input t_tree_link want);
        bit taken;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_src_vertex <= src;
        i_dst_vertex <= dst;
        i_edge_cost <= cost;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        if (act != ACT_NOP) items_sent++;
        case (act)
            ACT_CLEAR: begin
                foreach (link_on[a, b]) link_on[a][b] = 1'b0;
            end
            ACT_ADD: begin
                link_cost[src][dst] = cost;
                link_cost[dst][src] = cost;
                link_on[src][dst] = 1'b1;
                link_on[dst][src] = 1'b1;
            end
            ACT_RUN: begin
                runs_sent++;
                if (typed) tree_q.push_back(want);
                else grow_tree();
            end
            default: ;
        endcase
    endtask

    function automatic logic signed [15:0] rand_cost();
        case ($urandom_range(3))
            0: return 16'($urandom_range(8)) - 16'sd4;
            1: return 16'($urandom);
            2: return $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
            default: return 16'($urandom_range(100));
        endcase
    endfunction

    task automatic send_random_add(input int span);
        send_item(ACT_ADD, 5'($urandom_range(span - 1)), 5'($urandom_range(span - 1)),
                  rand_cost(), 1'b0, NO_LINK);
    endtask

    task automatic write_count(input logic [5:0] val);
        bit taken;
        i_in_valid <= 1'b0;
        while (tree_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        count_writes++;
        n_verts = (val == 0) ? 1 : (val > VERTS) ? VERTS : int'(val);
    endtask

    initial begin
        int base;
        int done;
        int links;
        int tail;
        int phase;
        bit pressed;
        logic [5:0] cv;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_action <= ACT_CLEAR;
        i_src_vertex <= '0;
        i_dst_vertex <= '0;
        i_edge_cost <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        i_out_stall <= 1'b0;
        foreach (link_on[a, b]) link_on[a][b] = 1'b0;
        pressed = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (PLAN[k]) begin
            if (PLAN[k].set_count) write_count(PLAN[k].count_val);
            else send_item(PLAN[k].action, PLAN[k].src, PLAN[k].dst, PLAN[k].cost,
                           PLAN[k].typed, PLAN[k].want);
        end

        base = items_sent;
        done = 0;
        while (done < RAND_ITEMS) begin
            phase = done * 4 / RAND_ITEMS;
            in_idle_pct = IDLE_PCT[phase];
            stall_pct = STALL_PCT[phase];
            if (done == 0) begin
                write_count(6'd12);
            end else if ($urandom_range(3) == 0) begin
                case ($urandom_range(9))
                    0: cv = 6'd1;
                    1: cv = 6'd32;
                    2: cv = 6'($urandom_range(63));
                    default: cv = 6'($urandom_range(10, 2));
                endcase
                write_count(cv);
            end
            if ($urandom_range(2) == 0)
                send_item(ACT_CLEAR, 5'($urandom), 5'($urandom), 16'($urandom), 1'b0, NO_LINK);
            links = $urandom_range(2 * n_verts, 1);
            repeat (links) begin
                if ($urandom_range(9) != 0) begin
                    send_random_add(n_verts);
                end else begin
                    case ($urandom_range(2))
                        0: send_random_add(VERTS);
                        1: send_item(ACT_NOP, 5'($urandom), 5'($urandom), 16'($urandom),
                                     1'b0, NO_LINK);
                        default: send_item(ACT_CLEAR, 5'($urandom), 5'($urandom),
                                           16'($urandom), 1'b0, NO_LINK);
                    endcase
                end
            end
            // hold the receiver off so the run backs up into the input
            if (!pressed && n_verts >= 6) begin
                hold_ask++;
                pressed = 1'b1;
                tail = 6;
            end else begin
                tail = $urandom_range(2);
            end
            send_item(ACT_RUN, 5'($urandom), 5'($urandom), 16'($urandom), 1'b0, NO_LINK);
            repeat (tail) send_random_add(n_verts);
            done = items_sent - base;
        end

        i_in_valid <= 1'b0;
        while (tree_q.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items with %0d tree runs and %0d count writes,", items_sent,
                 runs_sent, count_writes);
        $display("checking %0d tree links against the predictor (%0d mismatches).",
                 links_checked, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
